FILE: rtl/eau_pkg.sv
// shared types, constants and cordic arctangent table for the euler angle to unitary block
package eau_pkg;

    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_OUT_FRAC_BITS = 15;

    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_FRAC  = 30;
    localparam int TURN_W       = 32;
    localparam int VEC_W        = 33;
    localparam int CORDIC_X0    = 652032874;

    localparam int NUM_LANES   = 5;
    localparam int LANE_GAMMA  = 0;
    localparam int NUM_ENTRIES = 4;
    localparam int NUM_RESULTS = 2 * NUM_ENTRIES;
    localparam int PROD_W      = 2 * VEC_W;
    localparam int PROD_STAGES = 3;
    localparam int PIPE_DEPTH  = CORDIC_STEPS + PROD_STAGES;

    typedef struct packed {
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic signed [TURN_W-1:0] z;
        logic [1:0]               quad;
    } lane_t;

    typedef lane_t [NUM_LANES-1:0] lane_arr_t;

    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/euler_angles_to_unitary.sv
// top level: phase sums, chain of cordic cells and product unit forming the 2x2 unitary
//
// usage
//   input channel: in_valid, in_stall and the four angle ports; a request is taken
//   at a rising edge with in_valid high and in_stall low. angles are unsigned binary
//   angles, 2^ANGLE_BITS is a full turn.
//   output channel: out_valid, out_stall and the eight entry ports, signed with
//   OUT_FRAC_BITS fraction bits; a result is taken when out_valid is high and
//   out_stall low. one result per request, in request order.
//   pipeline: 31 cordic cells, then the quadrant fold, multiply and round stages.
//   throughput: one request per cycle while out_stall is low; every cell and product
//   stage then passes data on each cycle.
//   stall: each stage moves whenever the stage after it is empty or moving, so gaps
//   close up; in_stall rises only when all 34 stages hold requests and out_stall is
//   high. a waiting result holds its ports unchanged.
//   reset: rst_n clears all stage valid flags; nothing in flight survives it.
//
module euler_angles_to_unitary
    import eau_pkg::*;
#(
    parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ANGLE_BITS-1:0]      phase_angle,
    input  logic [ANGLE_BITS-1:0]      first_z_angle,
    input  logic [ANGLE_BITS-1:0]      y_angle,
    input  logic [ANGLE_BITS-1:0]      second_z_angle,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_FRAC_BITS:0] u00_real,
    output logic signed [OUT_FRAC_BITS:0] u00_imag,
    output logic signed [OUT_FRAC_BITS:0] u01_real,
    output logic signed [OUT_FRAC_BITS:0] u01_imag,
    output logic signed [OUT_FRAC_BITS:0] u10_real,
    output logic signed [OUT_FRAC_BITS:0] u10_imag,
    output logic signed [OUT_FRAC_BITS:0] u11_real,
    output logic signed [OUT_FRAC_BITS:0] u11_imag
);

    localparam int PH_W  = ANGLE_BITS + 1;
    localparam int UP    = TURN_W - PH_W;
    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [PH_W-1:0]   alpha2, beta_x, delta_x;
    logic [PH_W-1:0]   phase [NUM_ENTRIES];
    logic [TURN_W-1:0] turn [NUM_LANES];

    lane_arr_t chain_lanes [CORDIC_STEPS+1];
    logic      chain_valid [CORDIC_STEPS+1];
    logic      chain_ready [CORDIC_STEPS+1];

    logic [NUM_RESULTS-1:0][OUT_FRAC_BITS:0] result;

    logic [CNT_W-1:0] in_flight_reg;
    logic [CNT_W-1:0] in_flight_next;
    logic             in_take;
    logic             out_take;

    // phases at one extra bit so halving beta and delta is exact
    assign alpha2  = {phase_angle, 1'b0};
    assign beta_x  = {1'b0, first_z_angle};
    assign delta_x = {1'b0, second_z_angle};

    assign phase[0] = alpha2 - beta_x - delta_x;
    assign phase[1] = alpha2 - beta_x + delta_x;
    assign phase[2] = alpha2 + beta_x - delta_x;
    assign phase[3] = alpha2 + beta_x + delta_x;

    always_comb
    begin
        turn[LANE_GAMMA] = {1'b0, y_angle, {UP{1'b0}}};
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            turn[k + 1] = {phase[k], {UP{1'b0}}};
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            chain_lanes[0][l].x    = VEC_W'(CORDIC_X0);
            chain_lanes[0][l].y    = '0;
            chain_lanes[0][l].z    = {2'b00, turn[l][TURN_W-3:0]};
            chain_lanes[0][l].quad = turn[l][TURN_W-1:TURN_W-2];
        end
    end

    assign chain_valid[0] = in_valid;
    assign in_stall       = !chain_ready[0];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        eau_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_lanes  (chain_lanes[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_lanes (chain_lanes[i+1])
        );
    end

    eau_product #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_ready  (chain_ready[CORDIC_STEPS]),
        .in_lanes  (chain_lanes[CORDIC_STEPS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign u00_real = result[0];
    assign u00_imag = result[1];
    assign u01_real = result[2];
    assign u01_imag = result[3];
    assign u10_real = result[4];
    assign u10_imag = result[5];
    assign u11_real = result[6];
    assign u11_imag = result[7];

    // occupancy count of requests between the two ports
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        in_flight_next = in_flight_reg + CNT_W'(in_take) - CNT_W'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    a_out_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_flight_reg != '0)
        else $error("result shown with no request in flight");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_flight_reg == CNT_W'(PIPE_DEPTH)) && out_stall)
        else $error("input stalled while the pipeline has room");
`endif

endmodule

FILE: rtl/eau_cordic_cell.sv
// one cordic rotation step applied to all five angle lanes, with its own pipeline register
module eau_cordic_cell
    import eau_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lane_arr_t in_lanes,
    output logic      out_valid,
    input  logic      out_ready,
    output lane_arr_t out_lanes
);

    localparam logic signed [TURN_W-1:0] ATAN = atan_turn(STEP);

    logic      valid_reg;
    logic      valid_next;
    lane_arr_t lanes_reg;
    lane_arr_t lanes_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb
    begin
        lanes_next = in_lanes;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (in_lanes[l].z[TURN_W-1])
            begin
                lanes_next[l].x = in_lanes[l].x + ($signed(in_lanes[l].y) >>> STEP);
                lanes_next[l].y = in_lanes[l].y - ($signed(in_lanes[l].x) >>> STEP);
                lanes_next[l].z = in_lanes[l].z + ATAN;
            end
            else
            begin
                lanes_next[l].x = in_lanes[l].x - ($signed(in_lanes[l].y) >>> STEP);
                lanes_next[l].y = in_lanes[l].y + ($signed(in_lanes[l].x) >>> STEP);
                lanes_next[l].z = in_lanes[l].z - ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

FILE: rtl/eau_product.sv
// quadrant fold, complex entry products and rounding to the saturated output format
module eau_product
    import eau_pkg::*;
#(
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  lane_arr_t                                in_lanes,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [NUM_RESULTS-1:0][OUT_FRAC_BITS:0]  result
);

    localparam int OUT_W  = OUT_FRAC_BITS + 1;
    localparam int SHIFT  = 2 * CORDIC_FRAC - OUT_FRAC_BITS;
    localparam int QUOT_W = PROD_W - SHIFT;
    localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (SHIFT - 1);
    localparam logic [OUT_W-1:0]  MAX_V  = {1'b0, {OUT_FRAC_BITS{1'b1}}};
    localparam logic [OUT_W-1:0]  MIN_V  = {1'b1, {OUT_FRAC_BITS{1'b0}}};

    logic map_valid_reg, map_valid_next;
    logic mul_valid_reg, mul_valid_next;
    logic res_valid_reg, res_valid_next;
    logic map_ready, mul_ready, res_ready;

    logic signed [VEC_W-1:0] cos_v [NUM_LANES];
    logic signed [VEC_W-1:0] sin_v [NUM_LANES];

    logic signed [VEC_W-1:0]  pc_reg [NUM_ENTRIES];
    logic signed [VEC_W-1:0]  ps_reg [NUM_ENTRIES];
    logic signed [VEC_W-1:0]  mag_reg [NUM_ENTRIES];
    logic signed [VEC_W-1:0]  mag_next [NUM_ENTRIES];
    logic signed [PROD_W-1:0] prod_reg [NUM_RESULTS];
    logic [NUM_RESULTS-1:0][OUT_W-1:0] res_reg;
    logic [NUM_RESULTS-1:0][OUT_W-1:0] res_next;

    assign res_ready = !res_valid_reg || !out_stall;
    assign mul_ready = !mul_valid_reg || res_ready;
    assign map_ready = !map_valid_reg || mul_ready;
    assign in_ready  = map_ready;

    always_comb
    begin
        map_valid_next = map_ready ? in_valid : map_valid_reg;
        mul_valid_next = mul_ready ? map_valid_reg : mul_valid_reg;
        res_valid_next = res_ready ? mul_valid_reg : res_valid_reg;
    end

    // fold the quadrant back into cos and sin
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            unique case (in_lanes[l].quad)
                2'd0:
                begin
                    cos_v[l] = in_lanes[l].x;
                    sin_v[l] = in_lanes[l].y;
                end
                2'd1:
                begin
                    cos_v[l] = -in_lanes[l].y;
                    sin_v[l] = in_lanes[l].x;
                end
                2'd2:
                begin
                    cos_v[l] = -in_lanes[l].x;
                    sin_v[l] = -in_lanes[l].y;
                end
                default:
                begin
                    cos_v[l] = in_lanes[l].y;
                    sin_v[l] = -in_lanes[l].x;
                end
            endcase
        end
    end

    // u00 and u11 scale by cos, u10 by sin, u01 by minus sin
    always_comb
    begin
        mag_next[0] = cos_v[LANE_GAMMA];
        mag_next[1] = -sin_v[LANE_GAMMA];
        mag_next[2] = sin_v[LANE_GAMMA];
        mag_next[3] = cos_v[LANE_GAMMA];
    end

    always_comb
    begin
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] rnd;
        logic [QUOT_W-1:0] quo;
        logic              sat;
        logic [OUT_W-1:0]  pos;
        for (int r = 0; r < NUM_RESULTS; r++)
        begin
            neg = prod_reg[r][PROD_W-1];
            mag = neg ? PROD_W'(-prod_reg[r]) : PROD_W'(prod_reg[r]);
            rnd = mag + HALF;
            quo = rnd[PROD_W-1:SHIFT];
            sat = |quo[QUOT_W-1:OUT_FRAC_BITS];
            pos = {1'b0, quo[OUT_FRAC_BITS-1:0]};
            if (sat)
            begin
                res_next[r] = neg ? MIN_V : MAX_V;
            end
            else
            begin
                res_next[r] = neg ? OUT_W'(-pos) : pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            map_valid_reg <= map_valid_next;
            mul_valid_reg <= mul_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && map_ready)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                pc_reg[k]  <= cos_v[k + 1];
                ps_reg[k]  <= sin_v[k + 1];
                mag_reg[k] <= mag_next[k];
            end
        end
        if (map_valid_reg && mul_ready)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                prod_reg[2 * k]     <= pc_reg[k] * mag_reg[k];
                prod_reg[2 * k + 1] <= ps_reg[k] * mag_reg[k];
            end
        end
        if (mul_valid_reg && res_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign result    = res_reg;

endmodule
